// ===== hw/rtl/qty_pkg.sv =====
package qty_pkg;

  // Datapath widths. The vector needs 35 bits for the largest CORDIC
  // growth of a 34-bit term; one guard bit on top of that.
  localparam int unsigned QuatW  = 16;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned VecW   = 36;
  localparam int unsigned AtanW  = 32;
  localparam int unsigned AccW   = 34;
  localparam int unsigned YawW   = 16;

  localparam logic signed [VecW-1:0] OneQ28    = VecW'(1 << 28);
  localparam logic signed [AccW-1:0] HalfPiQ30 = AccW'(1686629713);
  localparam int                     YawLimit  = 25736;

  // Rotation state handed from cell to cell.
  typedef struct packed {
    logic                   zero;
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [AccW-1:0] acc;
  } cordic_data_t;

  // atan(2^-i) in Q.30, rounded to nearest.
  function automatic logic [AtanW-1:0] atan_q30(input logic [4:0] idx);
    logic [AtanW-1:0] val;
    case (idx)
      5'd0:    val = 32'd843314857;
      5'd1:    val = 32'd497837829;
      5'd2:    val = 32'd263043837;
      5'd3:    val = 32'd133525159;
      5'd4:    val = 32'd67021687;
      5'd5:    val = 32'd33543516;
      5'd6:    val = 32'd16775851;
      5'd7:    val = 32'd8388437;
      5'd8:    val = 32'd4194283;
      5'd9:    val = 32'd2097149;
      5'd10:   val = 32'd1048576;
      5'd11:   val = 32'd524288;
      5'd12:   val = 32'd262144;
      5'd13:   val = 32'd131072;
      5'd14:   val = 32'd65536;
      5'd15:   val = 32'd32768;
      5'd16:   val = 32'd16384;
      5'd17:   val = 32'd8192;
      5'd18:   val = 32'd4096;
      5'd19:   val = 32'd2048;
      5'd20:   val = 32'd1024;
      5'd21:   val = 32'd512;
      5'd22:   val = 32'd256;
      5'd23:   val = 32'd128;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/qty_terms.sv =====
// Products, sine/cosine terms, quadrant pre-rotation: three stages.
module qty_terms (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [qty_pkg::QuatW-1:0]       quat_w_i,
  input  logic signed [qty_pkg::QuatW-1:0]       quat_x_i,
  input  logic signed [qty_pkg::QuatW-1:0]       quat_y_i,
  input  logic signed [qty_pkg::QuatW-1:0]       quat_z_i,
  output logic                                   valid_o,
  output qty_pkg::cordic_data_t                  data_o
);

  logic [2:0] valid_q;

  logic signed [qty_pkg::ProdW-1:0] p_wz_q, p_xy_q, p_yy_q, p_zz_q;
  logic signed [qty_pkg::VecW-1:0]  s_d, c_d, s_q, c_q;
  qty_pkg::cordic_data_t            data_d, data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    p_wz_q <= quat_w_i * quat_z_i;
    p_xy_q <= quat_x_i * quat_y_i;
    p_yy_q <= quat_y_i * quat_y_i;
    p_zz_q <= quat_z_i * quat_z_i;
  end

  // stage 2: S = 2(wz+xy), C = 1 - 2(y^2+z^2), Q.28
  always_comb begin
    s_d = (qty_pkg::VecW'(p_wz_q) + qty_pkg::VecW'(p_xy_q)) <<< 1;
    c_d = qty_pkg::OneQ28 - ((qty_pkg::VecW'(p_yy_q) + qty_pkg::VecW'(p_zz_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    c_q <= c_d;
  end

  // stage 3: quarter turn into the right half plane
  always_comb begin
    data_d.zero = (s_q == '0) && (c_q == '0);
    data_d.vx   = c_q;
    data_d.vy   = s_q;
    data_d.acc  = '0;
    if (c_q[qty_pkg::VecW-1]) begin
      if (!s_q[qty_pkg::VecW-1]) begin
        data_d.vx  = s_q;
        data_d.vy  = -c_q;
        data_d.acc = qty_pkg::HalfPiQ30;
      end else begin
        data_d.vx  = -s_q;
        data_d.vy  = c_q;
        data_d.acc = -qty_pkg::HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q[2];
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/qty_cordic_cell.sv =====
// One vectoring micro-rotation by atan(2^-STEP), registered.
module qty_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  qty_pkg::cordic_data_t data_i,
  output logic                  valid_o,
  output qty_pkg::cordic_data_t data_o
);

  localparam logic signed [qty_pkg::AccW-1:0] AtanStep =
    signed'(qty_pkg::AccW'(qty_pkg::atan_q30(5'(STEP))));

  logic                            valid_q;
  qty_pkg::cordic_data_t           data_d, data_q;
  logic signed [qty_pkg::VecW-1:0] dx, dy;

  always_comb begin
    dx     = data_i.vy >>> STEP;
    dy     = data_i.vx >>> STEP;
    data_d = data_i;
    if (!data_i.vy[qty_pkg::VecW-1]) begin
      data_d.vx  = data_i.vx + dx;
      data_d.vy  = data_i.vy - dy;
      data_d.acc = data_i.acc + AtanStep;
    end else begin
      data_d.vx  = data_i.vx - dx;
      data_d.vy  = data_i.vy + dy;
      data_d.acc = data_i.acc - AtanStep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/quaternion_to_yaw_unit.sv =====
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+----------------------------
// command  | start_i, busy_o, quat_{w,x,y,z}_i       | edge with start_i && !busy_o
// result   | done_o, yaw_angle_o                     | edge ending the done_o cycle
//
// Fully pipelined: busy_o stays low, one quaternion per clock.
// Stages: products, terms, quadrant pre-rotation, one CORDIC cell per iteration,
// then round/saturate to the output register.
// Reset (async, active low) clears only the valid bits along the pipe.
// The receiver cannot stall; each result shows for exactly one cycle.
module quaternion_to_yaw_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [qty_pkg::QuatW-1:0]     quat_w_i,
  input  logic signed [qty_pkg::QuatW-1:0]     quat_x_i,
  input  logic signed [qty_pkg::QuatW-1:0]     quat_y_i,
  input  logic signed [qty_pkg::QuatW-1:0]     quat_z_i,
  output logic                                 done_o,
  output logic signed [qty_pkg::YawW-1:0]      yaw_angle_o
);

  localparam int unsigned RndW = qty_pkg::AccW + 1;

  logic                  chain_valid [CORDIC_STEPS+1];
  qty_pkg::cordic_data_t chain_data  [CORDIC_STEPS+1];

  // Never blocks: every cycle can take a new command.
  assign busy_o = 1'b0;

  qty_terms u_terms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i && !busy_o),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (chain_valid[0]),
    .data_o   (chain_data[0])
  );

  // Row of CORDIC cells, cell i shifts by i.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    qty_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // Q.30 -> Q2.13: add half LSB, arithmetic shift, clamp to +-pi.
  logic signed [RndW-1:0]             rnd_sum, rnd_shift;
  logic signed [qty_pkg::YawW-1:0]    yaw_d, yaw_q;
  logic                               done_q;

  always_comb begin
    rnd_sum   = RndW'(chain_data[CORDIC_STEPS].acc) + RndW'(1 << 16);
    rnd_shift = rnd_sum >>> 17;
    if (chain_data[CORDIC_STEPS].zero) begin
      yaw_d = '0;
    end else if (rnd_shift > RndW'(qty_pkg::YawLimit)) begin
      yaw_d = qty_pkg::YawW'(qty_pkg::YawLimit);
    end else if (rnd_shift < RndW'(-qty_pkg::YawLimit)) begin
      yaw_d = qty_pkg::YawW'(-qty_pkg::YawLimit);
    end else begin
      yaw_d = rnd_shift[qty_pkg::YawW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q <= yaw_d;
  end

  assign done_o      = done_q;
  assign yaw_angle_o = yaw_q;

endmodule

// ===== hw/rtl/qty_checker.sv =====
module qty_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic signed [qty_pkg::YawW-1:0]   yaw_angle_o
);

  localparam int unsigned Latency = CORDIC_STEPS + 4;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy_o raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("result missing after a command transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Latency !done_o)
    else $error("result without a command transfer");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (yaw_angle_o <= 16'sd25736) && (yaw_angle_o >= -16'sd25736))
    else $error("yaw outside -pi..pi");

endmodule

bind quaternion_to_yaw_unit qty_checker #(
  .CORDIC_STEPS (CORDIC_STEPS)
) u_qty_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .yaw_angle_o (yaw_angle_o)
);

// ===== test/tb_quaternion_to_yaw_unit.sv =====
`timescale 1ns / 100ps

module tb_quaternion_to_yaw_unit;

  localparam int unsigned CORDIC_STEPS = 16;
  // Pipe depth from the top-level notes: products, terms, pre-rotation, cells, round.
  localparam int unsigned PIPE_DEPTH   = CORDIC_STEPS + 4;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam longint      HALF_PI_Q30  = 64'sd1686629713;
  localparam int          YAW_MAX      = 25736;
  localparam int          ONE_Q14      = 16384;
  localparam real         PI_R         = 3.14159265358979323846;

  typedef logic signed [qty_pkg::QuatW-1:0] quat_comp_t;
  typedef logic signed [qty_pkg::YawW-1:0]  yaw_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       start_i     = 1'b0;
  logic       busy_o;
  quat_comp_t quat_w_i    = '0;
  quat_comp_t quat_x_i    = '0;
  quat_comp_t quat_y_i    = '0;
  quat_comp_t quat_z_i    = '0;
  logic       done_o;
  yaw_t       yaw_angle_o;

  yaw_t       expected_yaw[$];
  yaw_t       yaw_want;
  int         mismatches  = 0;
  int         quiet_cycles = 0;
  // Random gaps on the command side; cleared for one long back-to-back stretch.
  bit         gaps_enabled = 1'b1;

  quaternion_to_yaw_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .quat_w_i   (quat_w_i),
    .quat_x_i   (quat_x_i),
    .quat_y_i   (quat_y_i),
    .quat_z_i   (quat_z_i),
    .done_o     (done_o),
    .yaw_angle_o(yaw_angle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // atan(2^-i) at Q.30, nearest.
  function automatic longint micro_angle_q30(input int unsigned idx);
    case (idx)
      0:       return 843314857;
      1:       return 497837829;
      2:       return 263043837;
      3:       return 133525159;
      4:       return 67021687;
      5:       return 33543516;
      6:       return 16775851;
      7:       return 8388437;
      8:       return 4194283;
      9:       return 2097149;
      default: return longint'(1) << (30 - idx);  // atan(2^-i) rounds to 2^-i from here on
    endcase
  endfunction

  // Yaw of one quaternion: exact Q.28 terms, vectoring CORDIC at Q.30, round half up
  // to Q2.13 and clamp to +-pi.
  function automatic yaw_t predict_yaw(input quat_comp_t qw, input quat_comp_t qx,
                                       input quat_comp_t qy, input quat_comp_t qz);
    longint w, x, y, z;
    longint sin_term, cos_term;
    longint vx, vy, acc, dx, dy, tmp;
    w = qw;
    x = qx;
    y = qy;
    z = qz;
    sin_term = 2 * (w * z + x * y);
    cos_term = (longint'(1) << 28) - 2 * (y * y + z * z);
    if (sin_term == 0 && cos_term == 0) return '0;
    vx  = cos_term;
    vy  = sin_term;
    acc = 0;
    // Left half plane: quarter turn into the right half first.
    if (vx < 0) begin
      if (vy >= 0) begin
        tmp = vx;
        vx  = vy;
        vy  = -tmp;
        acc = HALF_PI_Q30;
      end else begin
        tmp = vx;
        vx  = -vy;
        vy  = tmp;
        acc = -HALF_PI_Q30;
      end
    end
    for (int unsigned i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        acc = acc + micro_angle_q30(i);
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        acc = acc - micro_angle_q30(i);
      end
    end
    tmp = (acc + 65536) >>> 17;
    if (tmp > YAW_MAX)  tmp = YAW_MAX;
    if (tmp < -YAW_MAX) tmp = -YAW_MAX;
    return yaw_t'(tmp);
  endfunction

  // Command and result monitor. Inputs move on the falling edge, so both sides are
  // stable here. Results are checked before this edge's command is queued; a command
  // never leaves on the edge that takes it, so ordering within the edge never matters.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_yaw.size() == 0) begin
          $error("yaw_angle: expected nothing, got %0d", yaw_angle_o);
          mismatches++;
        end else begin
          yaw_want = expected_yaw.pop_front();
          if (yaw_angle_o !== yaw_want) begin
            $error("yaw_angle: expected %0d, got %0d", yaw_want, yaw_angle_o);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o)
        expected_yaw.push_back(predict_yaw(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
    end
  end

  // Hang detector: any transfer on either side clears the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("quaternion_to_yaw_unit verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One command transfer. Entered just after a rising edge; returns at the rising
  // edge that takes the command. start_i stays high between back-to-back items.
  task automatic send_quat(input quat_comp_t qw, input quat_comp_t qx,
                           input quat_comp_t qy, input quat_comp_t qz);
    int unsigned gap;
    gap = 0;
    if (gaps_enabled && $urandom_range(99) < 29) gap = $urandom_range(4, 1);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i  <= 1'b1;
    quat_w_i <= qw;
    quat_x_i <= qx;
    quat_y_i <= qy;
    quat_z_i <= qz;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic quat_comp_t to_q14(input real r);
    int v;
    v = $rtoi(r >= 0.0 ? r + 0.5 : r - 0.5);
    if (v > ONE_Q14)  v = ONE_Q14;
    if (v < -ONE_Q14) v = -ONE_Q14;
    return quat_comp_t'(v);
  endfunction

  // Directed: field extremes, each quadrant, axes, both-terms-zero, and the
  // rounding edge around +-pi.
  task automatic test_special_cases();
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);           // identity, yaw 0
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);               // all zero: C = 1, S = 0
    send_quat(16'sd0, 16'sd0, 16'sd8192, 16'sd8192);         // both terms zero
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192);  // both zero, products cancel
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);           // C < 0, S = 0 -> +pi
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);           // same via y
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);           // x axis, yaw 0
    send_quat(16'sd4096, 16'sd0, 16'sd0, 16'sd16384);        // C < 0, S > 0
    send_quat(16'sd4096, 16'sd0, 16'sd0, -16'sd16384);       // C < 0, S < 0
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd4096);        // C > 0, S > 0
    send_quat(16'sd16384, 16'sd0, 16'sd0, -16'sd4096);       // C > 0, S < 0
    send_quat(16'sd16384, 16'sd0, 16'sd8192, 16'sd8192);     // C = 0, S > 0 -> pi/2
    send_quat(16'sd16384, 16'sd0, -16'sd8192, -16'sd8192);   // C = 0, S < 0 -> -pi/2
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd16384);           // just below +pi
    send_quat(-16'sd1, 16'sd0, 16'sd0, 16'sd16384);          // just above -pi
    send_quat(16'sd0, 16'sd1, 16'sd16384, 16'sd0);           // near +pi via x*y
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_quat(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);      // -pi/2 by a 45 deg half angle
  endtask

  // Random unit quaternions, sometimes negated (same rotation). The middle hundred
  // go back to back with no gaps.
  task automatic test_random_orientations(input int unsigned count);
    real a, b, c, d, norm, sgn;
    for (int unsigned n = 0; n < count; n++) begin
      gaps_enabled = !(n >= count / 3 && n < count / 3 + 100);
      do begin
        a = real'(int'($urandom_range(32768)) - ONE_Q14);
        b = real'(int'($urandom_range(32768)) - ONE_Q14);
        c = real'(int'($urandom_range(32768)) - ONE_Q14);
        d = real'(int'($urandom_range(32768)) - ONE_Q14);
        norm = $sqrt(a * a + b * b + c * c + d * d);
      end while (norm < 1.0);
      sgn = $urandom_range(1) ? -1.0 : 1.0;
      send_quat(to_q14(sgn * a / norm * ONE_Q14), to_q14(sgn * b / norm * ONE_Q14),
                to_q14(sgn * c / norm * ONE_Q14), to_q14(sgn * d / norm * ONE_Q14));
    end
    gaps_enabled = 1'b1;
  endtask

  // Pure rotations about z over the whole circle, so the yaw sweeps every quadrant
  // and lands close to the +-pi seam.
  task automatic test_yaw_sweep(input int unsigned count);
    real ang;
    for (int unsigned n = 0; n < count; n++) begin
      ang = (real'($urandom_range(1000000)) / 1000000.0 * 2.0 - 1.0) * PI_R;
      send_quat(to_q14($cos(ang / 2.0) * ONE_Q14), 16'sd0, 16'sd0,
                to_q14($sin(ang / 2.0) * ONE_Q14));
    end
  endtask

  // Any 16-bit pattern, so every bit of every field can toggle.
  task automatic test_raw_patterns(input int unsigned count);
    for (int unsigned n = 0; n < count; n++)
      send_quat(quat_comp_t'($urandom), quat_comp_t'($urandom),
                quat_comp_t'($urandom), quat_comp_t'($urandom));
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_random_orientations(300);
    test_yaw_sweep(100);
    test_raw_patterns(100);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_yaw.size() != 0) @(posedge clk_i);
    // Extra cycles to catch any stray result still in the pipe.
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("quaternion_to_yaw_unit verification clean");
    end else begin
      $display("quaternion_to_yaw_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/qty_pkg.sv
hw/rtl/qty_terms.sv
hw/rtl/qty_cordic_cell.sv
hw/rtl/quaternion_to_yaw_unit.sv
hw/rtl/qty_checker.sv
test/tb_quaternion_to_yaw_unit.sv
